// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pcxrle_pkg.sv =====
package pcxrle_pkg;

    // Field widths fixed by the interface.
    localparam int VALUE_W     = 8;
    localparam int OUT_INDEX_W = 20;
    localparam int TOTAL_W     = 21;
    localparam int RUN_W       = 6;

    // A byte with both top bits set is a count byte.
    localparam logic [1:0]         COUNT_MARK  = 2'b11;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 21'd64000;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // Status of one pixel step.
    typedef struct packed {
        logic eoi;
        logic last;
    } step_status_t;

endpackage

// ===== hdl/pcxrle_step.sv =====
module pcxrle_step #(
    parameter int INDEX_BITS = 20,
    parameter int CMP_W      = 21
) (
    input  logic [INDEX_BITS-1:0]   counter,
    input  logic [CMP_W-1:0]        total,
    input  logic                    run_end,
    output pcxrle_pkg::step_status_t status,
    output logic [INDEX_BITS-1:0]   counter_next
);

    logic [CMP_W-1:0] count_plus;

    // The pixel is the final one of the image when the next position reaches the total.
    assign count_plus   = CMP_W'(counter) + CMP_W'(1);
    assign status.eoi   = (count_plus >= total);
    assign status.last  = status.eoi || run_end;

    // The position wraps to zero after the final pixel.
    assign counter_next = status.eoi ? '0 : count_plus[INDEX_BITS-1:0];

endmodule

// ===== hdl/pcx_rle_pixel_decoder_core.sv =====
// Literal byte: its pixel is in the output register in the cycle after the byte is accepted.
// Count byte: no pixel. Value byte of a run of N: up to N pixels, fewer if the image ends
// first, one pixel per cycle while the output is not stalled, and the input stalls until
// the run is done; one shared position step unit sets this rate. Literals stream at one per
// cycle while the output is taken without stall. Reset clears the sequencer, the run counts,
// the position counter and the output valid flag, and sets the pixel total to 64000.
module pcx_rle_pixel_decoder_core #(
    parameter int INDEX_BITS = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pcxrle_pkg::TOTAL_W-1:0]       total_pixels,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pcxrle_pkg::VALUE_W-1:0]       in_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pcxrle_pkg::VALUE_W-1:0]       pixel_value,
    output logic [pcxrle_pkg::OUT_INDEX_W-1:0]   pixel_index,
    output logic                                 last_of_run,
    output logic                                 end_of_image
);

    localparam int CMP_W = (INDEX_BITS + 1 > pcxrle_pkg::TOTAL_W) ?
                           INDEX_BITS + 1 : pcxrle_pkg::TOTAL_W;
    localparam int IW    = (INDEX_BITS > pcxrle_pkg::OUT_INDEX_W) ?
                           INDEX_BITS : pcxrle_pkg::OUT_INDEX_W;
    localparam logic [CMP_W-1:0] CAP       = CMP_W'(1) << INDEX_BITS;
    localparam logic [CMP_W-1:0] RESET_RAW = CMP_W'(pcxrle_pkg::TOTAL_RESET);
    localparam logic [CMP_W-1:0] RESET_EFF = (RESET_RAW > CAP) ? CAP : RESET_RAW;

    pcxrle_pkg::state_t                 state_reg, state_next;
    logic                               awaiting_reg, awaiting_next;
    logic [pcxrle_pkg::RUN_W-1:0]       pending_reg, pending_next;
    logic [pcxrle_pkg::RUN_W-1:0]       remain_reg, remain_next;
    logic [pcxrle_pkg::VALUE_W-1:0]     value_reg, value_next;
    logic [INDEX_BITS-1:0]              counter_reg, counter_next;
    logic [CMP_W-1:0]                   total_reg, total_next;

    logic                               out_valid_reg, out_valid_next;
    logic [pcxrle_pkg::VALUE_W-1:0]     out_value_reg, out_value_next;
    logic [pcxrle_pkg::OUT_INDEX_W-1:0] out_index_reg, out_index_next;
    logic                               out_last_reg, out_last_next;
    logic                               out_eoi_reg, out_eoi_next;

    logic                               out_free;
    logic                               in_fire;
    logic                               emit;
    logic                               run_end;
    logic [pcxrle_pkg::VALUE_W-1:0]     emit_value;
    logic [CMP_W-1:0]                   cfg_wide;
    logic [IW-1:0]                      index_wide;
    logic [INDEX_BITS-1:0]              step_counter_next;
    pcxrle_pkg::step_status_t           step_status;

    // Handshake decode.
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != pcxrle_pkg::ST_IDLE) || !out_free;
    assign in_fire   = in_valid && !in_stall;

    // A pixel closes its byte's run when it is a literal or the final pixel of a run.
    assign run_end = (state_reg == pcxrle_pkg::ST_RUN) ?
                     (remain_reg == pcxrle_pkg::RUN_W'(1)) :
                     (!awaiting_reg || (pending_reg == pcxrle_pkg::RUN_W'(1)));

    // Shared position step unit.
    pcxrle_step #(
        .INDEX_BITS (INDEX_BITS),
        .CMP_W      (CMP_W)
    ) u_step (
        .counter      (counter_reg),
        .total        (total_reg),
        .run_end      (run_end),
        .status       (step_status),
        .counter_next (step_counter_next)
    );

    // Sequencer: decode bytes in idle, walk runs one pixel per cycle while the output is free.
    always_comb
    begin
        state_next    = state_reg;
        awaiting_next = awaiting_reg;
        pending_next  = pending_reg;
        remain_next   = remain_reg;
        value_next    = value_reg;
        emit          = 1'b0;
        emit_value    = value_reg;
        case (state_reg)
            pcxrle_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (awaiting_reg)
                    begin
                        awaiting_next = 1'b0;
                        pending_next  = '0;
                        emit          = (pending_reg != '0);
                        emit_value    = in_byte;
                        remain_next   = pending_reg - pcxrle_pkg::RUN_W'(1);
                        value_next    = in_byte;
                    end
                    else if (in_byte[7:6] == pcxrle_pkg::COUNT_MARK)
                    begin
                        awaiting_next = 1'b1;
                        pending_next  = in_byte[pcxrle_pkg::RUN_W-1:0];
                    end
                    else
                    begin
                        emit       = 1'b1;
                        emit_value = in_byte;
                    end
                    if (emit && !step_status.last)
                    begin
                        state_next = pcxrle_pkg::ST_RUN;
                    end
                end
            end
            pcxrle_pkg::ST_RUN:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_value  = value_reg;
                    remain_next = remain_reg - pcxrle_pkg::RUN_W'(1);
                    if (step_status.last)
                    begin
                        state_next = pcxrle_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = pcxrle_pkg::ST_IDLE;
            end
        endcase
    end

    // Position counter advances on every emitted pixel.
    assign counter_next = emit ? step_counter_next : counter_reg;

    // Clamp the pixel total into the range the counter can reach.
    assign cfg_wide = CMP_W'(total_pixels);
    always_comb
    begin
        total_next = total_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_wide == '0)
            begin
                total_next = CMP_W'(1);
            end
            else if (cfg_wide > CAP)
            begin
                total_next = CAP;
            end
            else
            begin
                total_next = cfg_wide;
            end
        end
    end

    // Output register holds one pixel request until it is taken.
    assign index_wide = IW'(counter_reg);
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        out_eoi_next   = out_eoi_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_value_next = emit_value;
            out_index_next = index_wide[pcxrle_pkg::OUT_INDEX_W-1:0];
            out_last_next  = step_status.last;
            out_eoi_next   = step_status.eoi;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcxrle_pkg::ST_IDLE;
            awaiting_reg  <= 1'b0;
            pending_reg   <= '0;
            remain_reg    <= '0;
            counter_reg   <= '0;
            total_reg     <= RESET_EFF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            awaiting_reg  <= awaiting_next;
            pending_reg   <= pending_next;
            remain_reg    <= remain_next;
            counter_reg   <= counter_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        out_value_reg <= out_value_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
        out_eoi_reg   <= out_eoi_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_value  = out_value_reg;
    assign pixel_index  = out_index_reg;
    assign last_of_run  = out_last_reg;
    assign end_of_image = out_eoi_reg;

endmodule

// ===== hdl/pcxrle_checker.sv =====
`include "assert_macros.svh"

module pcxrle_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [pcxrle_pkg::VALUE_W-1:0]       pixel_value,
    input logic [pcxrle_pkg::OUT_INDEX_W-1:0]   pixel_index,
    input logic                                 last_of_run,
    input logic                                 end_of_image
);

    // A stalled pixel request keeps its payload.
    `ASSERT_CLKD(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(pixel_value) && $stable(pixel_index) && $stable(last_of_run) && $stable(end_of_image), "stalled pixel changed")

    // No new byte is taken while a pixel is blocked at the output.
    `ASSERT_CLKD(a_in_blocked, clk, rst_n, out_valid && out_stall |-> in_stall, "input taken while output blocked")

    // Inside a run the next pixel follows at once with the next position and the same value.
    `ASSERT_CLKD(a_run_step, clk, rst_n, out_valid && !out_stall && !last_of_run |=> out_valid && pixel_index == $past(pixel_index) + 20'd1 && pixel_value == $past(pixel_value), "run pixel out of sequence")

    // After the final pixel of an image the position starts again at zero.
    `ASSERT_CLKD(a_image_wrap, clk, rst_n, out_valid && !out_stall && end_of_image |=> !out_valid || pixel_index == '0, "position not cleared after image end")

endmodule

bind pcx_rle_pixel_decoder_core pcxrle_checker u_pcxrle_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_value  (pixel_value),
    .pixel_index  (pixel_index),
    .last_of_run  (last_of_run),
    .end_of_image (end_of_image)
);

// ===== dv/tb_pcx_rle_pixel_decoder_core.sv =====
module tb_pcx_rle_pixel_decoder_core;

    import pcxrle_pkg::*;

    localparam int INDEX_BITS = 20;
    // Cycles the block may still be busy after the last pixel (longest run plus margin).
    localparam int SETTLE_CYCLES = 70;

    // One decoded pixel as seen on the output port.
    typedef struct packed {
        logic [VALUE_W-1:0]     value;
        logic [OUT_INDEX_W-1:0] index;
        logic                   last;
        logic                   eoi;
    } pixel_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_TOTAL
    } row_kind_t;

    // One line of the directed stimulus table.
    typedef struct packed {
        row_kind_t          kind;
        logic [TOTAL_W-1:0] data;
        logic               fixed;
        pixel_t             want;
    } row_t;

    localparam pixel_t NO_PIXEL = '0;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [TOTAL_W-1:0]     total_pixels = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [VALUE_W-1:0]     in_byte = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [VALUE_W-1:0]     pixel_value;
    logic [OUT_INDEX_W-1:0] pixel_index;
    logic                   last_of_run;
    logic                   end_of_image;

    // Decoder state as predicted by the testbench.
    logic [TOTAL_W-1:0]     total_cfg = TOTAL_RESET;
    logic                   run_armed = 1'b0;
    logic [RUN_W-1:0]       run_len = '0;
    logic [INDEX_BITS-1:0]  next_pos = '0;

    pixel_t pending_pixels[$];
    row_t   plan[$];
    int     errors = 0;
    bit     calm = 1'b0;
    int     stall_left = 0;

    pcx_rle_pixel_decoder_core #(
        .INDEX_BITS(INDEX_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .total_pixels(total_pixels),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_byte(in_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pixel_value(pixel_value),
        .pixel_index(pixel_index),
        .last_of_run(last_of_run),
        .end_of_image(end_of_image)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Length of an idle stretch: none in calm phases, else mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [VALUE_W-1:0] run_of(input logic [RUN_W-1:0] len);
        return {COUNT_MARK, len};
    endfunction

    function automatic row_t plain_row(input row_kind_t kind, input logic [TOTAL_W-1:0] data);
        row_t r;
        r.kind = kind;
        r.data = data;
        r.fixed = 1'b0;
        r.want = NO_PIXEL;
        return r;
    endfunction

    // A byte row checked against the predictor.
    function automatic row_t byte_row(input logic [VALUE_W-1:0] b);
        return plain_row(ROW_BYTE, TOTAL_W'(b));
    endfunction

    function automatic row_t typed_row(input logic [VALUE_W-1:0] b,
                                       input logic [OUT_INDEX_W-1:0] idx,
                                       input logic last, input logic eoi);
        row_t r;
        r.kind = ROW_BYTE;
        r.data = TOTAL_W'(b);
        r.fixed = 1'b1;
        r.want = '{b, idx, last, eoi};
        return r;
    endfunction

    // Advances the predicted decoder by one accepted byte and queues the pixels it yields.
    // With fixed set, the typed-in pixel is queued in place of the computed one.
    function automatic void decode_byte(input logic [VALUE_W-1:0] b, input logic fixed,
                                        input pixel_t fixed_px);
        int unsigned limit;
        int unsigned count;
        int unsigned pos;
        pixel_t      px;
        limit = 32'(total_cfg);
        if (limit == 0)
            limit = 1;
        if (limit > (1 << INDEX_BITS))
            limit = 1 << INDEX_BITS;
        if (run_armed)
        begin
            count = 32'(run_len);
            run_armed = 1'b0;
            run_len = '0;
        end
        else if (b[VALUE_W-1 -: 2] == COUNT_MARK)
        begin
            // A count byte only arms the run.
            run_armed = 1'b1;
            run_len = b[RUN_W-1:0];
            return;
        end
        else
        begin
            count = 1;
        end
        for (int n = 0; n < count; n++)
        begin
            pos = 32'(next_pos);
            px.value = b;
            px.index = OUT_INDEX_W'(pos);
            px.eoi = (pos + 1 >= limit);
            px.last = px.eoi || (n + 1 == count);
            pending_pixels.push_back(fixed ? fixed_px : px);
            // The image ends here: the rest of the run is dropped.
            if (px.eoi)
            begin
                next_pos = '0;
                break;
            end
            next_pos = INDEX_BITS'(pos + 1);
        end
    endfunction

    // Sends one byte after a random gap and predicts its pixels once it is accepted.
    task automatic push_byte(input logic [VALUE_W-1:0] b, input logic fixed,
                             input pixel_t fixed_px);
        int gap;
        gap = idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b, fixed, fixed_px);
    endtask

    // Holds off the input until every predicted pixel has come out and the block is quiet.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_total(input logic [TOTAL_W-1:0] t);
        @(negedge clk);
        cfg_valid <= 1'b1;
        total_pixels <= t;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        total_cfg = t;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Output back-pressure: random stall bursts, none during calm phases.
    always @(negedge clk)
    begin
        logic s;
        s = 1'b0;
        if (!rst_n)
            stall_left = 0;
        else if (stall_left > 0)
        begin
            s = 1'b1;
            stall_left--;
        end
        else
        begin
            stall_left = idle_len();
            if (stall_left > 0)
            begin
                s = 1'b1;
                stall_left--;
            end
        end
        out_stall <= s;
    end

    // Compares every accepted pixel with the oldest prediction.
    always @(posedge clk)
    begin
        pixel_t want;
        pixel_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {pixel_value, pixel_index, last_of_run, end_of_image};
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: pixel with none expected: value %h index %0d last %b eoi %b",
                         $time, got.value, got.index, got.last, got.eoi);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display({"%0t: expected value %h index %0d last %b eoi %b, ",
                              "got value %h index %0d last %b eoi %b"},
                             $time, want.value, want.index, want.last, want.eoi,
                             got.value, got.index, got.last, got.eoi);
                end
            end
        end
    end

    initial
    begin
        int                 r;
        int                 sent;
        logic [RUN_W-1:0]   len;
        logic [TOTAL_W-1:0] t;

        // Directed table: literals after reset, runs of every kind, then the total corners.
        plan.push_back(typed_row(8'h00, 20'd0, 1'b1, 1'b0));
        plan.push_back(typed_row(8'hBF, 20'd1, 1'b1, 1'b0));
        plan.push_back(typed_row(8'h40, 20'd2, 1'b1, 1'b0));
        plan.push_back(typed_row(8'h80, 20'd3, 1'b1, 1'b0));
        plan.push_back(byte_row(run_of(6'd3)));
        plan.push_back(byte_row(8'hFF));
        // A zero-length run swallows its value byte.
        plan.push_back(byte_row(run_of(6'd0)));
        plan.push_back(byte_row(8'h55));
        // Longest run, with a value that looks like a count byte.
        plan.push_back(byte_row(run_of(6'd63)));
        plan.push_back(byte_row(run_of(6'd63)));
        plan.push_back(byte_row(run_of(6'd1)));
        plan.push_back(byte_row(8'h2A));
        // Lower the total below the current position.
        plan.push_back(plain_row(ROW_TOTAL, 21'd8));
        plan.push_back(byte_row(8'h12));
        plan.push_back(byte_row(8'h13));
        // A run that runs past the end of the image.
        plan.push_back(byte_row(run_of(6'd10)));
        plan.push_back(byte_row(8'h33));
        plan.push_back(byte_row(8'h01));
        // A total of zero acts as one.
        plan.push_back(plain_row(ROW_TOTAL, 21'd0));
        plan.push_back(byte_row(8'h7F));
        plan.push_back(byte_row(run_of(6'd5)));
        plan.push_back(byte_row(8'h80));
        plan.push_back(plain_row(ROW_TOTAL, 21'd1));
        plan.push_back(byte_row(8'h3C));
        // A total above the index range is clamped.
        plan.push_back(plain_row(ROW_TOTAL, 21'h1FFFFF));
        plan.push_back(byte_row(run_of(6'd2)));
        plan.push_back(byte_row(8'hA5));
        plan.push_back(plain_row(ROW_TOTAL, 21'd1048576));
        plan.push_back(byte_row(8'h00));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_TOTAL)
            begin
                settle();
                write_total(plan[k].data);
            end
            else
            begin
                push_byte(plan[k].data[VALUE_W-1:0], plan[k].fixed, plan[k].want);
            end
        end

        // Random phases, each with its own total and idling mode.
        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            case ($urandom_range(0, 7))
                0: t = 21'd1;
                1: t = 21'd0;
                2: t = 21'h1FFFFF;
                3: t = 21'd1048576;
                4: t = TOTAL_W'($urandom_range(2, 40));
                5: t = TOTAL_W'($urandom_range(41, 2000));
                6: t = TOTAL_W'($urandom);
                default: t = TOTAL_RESET;
            endcase
            write_total(t);
            calm = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < 25)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    push_byte(VALUE_W'($urandom_range(0, 191)), 1'b0, NO_PIXEL);
                    sent++;
                end
                else if (r < 90)
                begin
                    if ($urandom_range(0, 9) == 0)
                        len = ($urandom_range(0, 1) != 0) ? 6'd63 :
                              RUN_W'($urandom_range(0, 63));
                    else
                        len = RUN_W'($urandom_range(0, 12));
                    push_byte(run_of(len), 1'b0, NO_PIXEL);
                    push_byte(VALUE_W'($urandom_range(0, 255)), 1'b0, NO_PIXEL);
                    sent += 2;
                end
                else
                begin
                    // Any byte at all, which may leave a run armed across the next item.
                    push_byte(VALUE_W'($urandom_range(0, 255)), 1'b0, NO_PIXEL);
                    sent++;
                end
            end
        end
        calm = 1'b0;

        settle();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Overall time limit.
    initial
    begin
        #10000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== pcx_rle_pixel_decoder_core.f =====
+incdir+hdl
hdl/pcxrle_pkg.sv
hdl/pcxrle_step.sv
hdl/pcx_rle_pixel_decoder_core.sv
hdl/pcxrle_checker.sv
dv/tb_pcx_rle_pixel_decoder_core.sv
